// ===== rtl/bitmap_slot_allocator_assert.svh =====
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int unsigned ROW_W = 32;
  localparam int unsigned BIT_W = 5;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_MODIFY,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/bsa_req_if.sv =====
interface bsa_req_if #(
  parameter int IDX_W = 9
) ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [IDX_W-1:0] slot_index;

  modport source (output valid, action, slot_index, input ready);
  modport sink (input valid, action, slot_index, output ready);
endinterface

// ===== rtl/bsa_res_if.sv =====
interface bsa_res_if #(
  parameter int IDX_W = 9,
  parameter int CNT_W = 10
) ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] granted_slot;
  logic [CNT_W-1:0] free_count;
  logic             pool_empty;
  logic             pool_full;

  modport source (output valid, ok, granted_slot, free_count, pool_empty, pool_full,
                  input ready);
  modport sink (input valid, ok, granted_slot, free_count, pool_empty, pool_full,
                output ready);
endinterface

// ===== rtl/bsa_ram.sv =====
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// First-fit slot allocator over a pool of SLOTS slots. One request is handled at a time and
// goes through these steps from acceptance to its result standing in the output register:
// accept it, pick the row (lowest row with a free bit for an allocate, the named row for a
// release) and start its read, read-modify-write that 32-bit row of the bitmap RAM, and
// load the result. A request that changes nothing (an allocate on an empty pool, or a
// release at or above the capacity) skips the read-modify-write.
// A new request is taken as soon as the previous result has been loaded, even while that result
// still waits to be taken; its own result then waits in the done state until the earlier one has
// gone. A capacity write is applied in the cycle it is seen; each row carries
// a flag that makes it read as its initial pattern until first written, so there is no clearing
// pass after reset or after a capacity write.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int SLOTS = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [$clog2(SLOTS + 1)-1:0]        cfg_wdata,
  bsa_req_if.sink                             req,
  bsa_res_if.source                           res
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ROWS  = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW    = RW + BIT_W;
  localparam int LW    = ((CNT_W > SW) ? CNT_W : SW) + 1;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  total;
  logic [ROWS-1:0]   summary;
  logic [ROWS-1:0]   fresh;
  logic              act;
  logic [SW-1:0]     slot;
  logic [RW-1:0]     row;
  logic              p_ok;
  logic [IDX_W-1:0]  p_slot;

  logic              accept;
  logic              go_modify;
  logic              ram_we;
  logic              out_load;
  logic [RW-1:0]     first_row;
  logic [RW-1:0]     row_sel;
  logic              in_range;
  logic [CNT_W-1:0]  cap_init;
  logic [ROWS-1:0]   summary_init;
  logic [LW-1:0]     row_lo;
  logic [LW-1:0]     n_free;
  logic [ROW_W-1:0]  pattern;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  word;
  logic [BIT_W-1:0]  first_bit;
  logic [BIT_W-1:0]  rel_bit;
  logic              rel_new;
  logic [ROW_W-1:0]  new_word;

  assign accept = req.valid && req.ready;

  // lowest row with a free slot
  always_comb begin
    first_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (summary[i]) begin
        first_row = RW'(i);
      end
    end
  end

  assign in_range  = LW'(slot) < LW'(cap);
  assign row_sel   = (act == ACT_ALLOC) ? first_row : slot[SW-1:BIT_W];
  assign go_modify = (act == ACT_ALLOC) ? (|summary) : in_range;

  // initial pattern of a row that has not been written since the last fill
  always_comb begin
    row_lo = LW'({row, {BIT_W{1'b0}}});
    n_free = LW'(cap) - row_lo;
    if (LW'(cap) <= row_lo) begin
      pattern = '0;
    end else if (n_free >= LW'(ROW_W)) begin
      pattern = '1;
    end else begin
      pattern = ~({ROW_W{1'b1}} << n_free[BIT_W-1:0]);
    end
  end

  assign word = fresh[row] ? pattern : ram_rdata;

  always_comb begin
    first_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        first_bit = BIT_W'(i);
      end
    end
  end

  assign rel_bit = slot[BIT_W-1:0];
  assign rel_new = !word[rel_bit];

  always_comb begin
    if (act == ACT_RELEASE) begin
      new_word = word | (ROW_W'(1) << rel_bit);
    end else begin
      new_word = word & ~(ROW_W'(1) << first_bit);
    end
  end

  // fill pattern for reset and capacity writes
  always_comb begin
    if (rst) begin
      cap_init = CNT_W'(SLOTS);
    end else if (LW'(cfg_wdata) > LW'(SLOTS)) begin
      cap_init = CNT_W'(SLOTS);
    end else begin
      cap_init = cfg_wdata;
    end
    for (int r = 0; r < ROWS; r++) begin
      summary_init[r] = (LW'(r) * LW'(ROW_W)) < LW'(cap_init);
    end
  end

  bsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (new_word),
    .raddr (row_sel),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = go_modify ? ST_MODIFY : ST_DONE;
      end
      ST_MODIFY: begin
        ram_we     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res.valid || res.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= req.action;
      slot <= SW'(req.slot_index);
    end
    if (state == ST_LOOKUP) begin
      row <= row_sel;
      if (!go_modify) begin
        p_ok   <= 1'b0;
        p_slot <= '0;
      end
    end
    if (state == ST_MODIFY) begin
      p_ok   <= 1'b1;
      p_slot <= (act == ACT_ALLOC) ? IDX_W'({row, first_bit}) : '0;
    end
    if (out_load) begin
      res.ok           <= p_ok;
      res.granted_slot <= p_slot;
      res.free_count   <= total;
      res.pool_empty   <= (total == '0);
      res.pool_full    <= (total == cap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      cap     <= cap_init;
      total   <= cap_init;
      fresh   <= '1;
      summary <= summary_init;
    end else if (state == ST_MODIFY) begin
      fresh[row]   <= 1'b0;
      summary[row] <= |new_word;
      if (act == ACT_ALLOC) begin
        total <= total - CNT_W'(1);
      end else if (rel_new) begin
        total <= total + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/bsa_checker.sv =====
`include "bitmap_slot_allocator_assert.svh"

module bsa_checker
  import bsa_pkg::*;
#(
  parameter int IDX_W = 9,
  parameter int CNT_W = 10
) (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_ok,
  input logic [IDX_W-1:0] res_granted_slot,
  input logic [CNT_W-1:0] res_free_count,
  input logic             res_pool_empty,
  input logic             res_pool_full
);

  // one request in flight: no second beat straight after an accepted one
  `BSA_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

  `BSA_ASSERT_IMPLY(a_empty_flag, clk, rst, res_valid, res_pool_empty == (res_free_count == '0))

  `BSA_ASSERT_IMPLY(a_no_grant_on_fail, clk, rst, res_valid && !res_ok, res_granted_slot == '0)

  `BSA_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
                   res_valid && $stable(res_ok) && $stable(res_granted_slot) &&
                   $stable(res_free_count) && $stable(res_pool_full))

endmodule

bind bitmap_slot_allocator bsa_checker #(
  .IDX_W (IDX_W),
  .CNT_W (CNT_W)
) u_bsa_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_ok           (res.ok),
  .res_granted_slot (res.granted_slot),
  .res_free_count   (res.free_count),
  .res_pool_empty   (res.pool_empty),
  .res_pool_full    (res.pool_full)
);

// ===== verif/bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  localparam int unsigned SLOTS = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] free_count;
    logic             empty;
    logic             full;
  } alloc_result_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             act;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cap;
    logic             typed;
    alloc_result_t    want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CNT_W-1:0] cfg_wdata;

  bsa_req_if #(.IDX_W(IDX_W)) req_bus ();
  bsa_res_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) res_bus ();

  bitmap_slot_allocator #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_bus),
    .res       (res_bus)
  );

  logic [SLOTS-1:0] model_free_map;
  int unsigned      model_free_total;
  int unsigned      model_capacity;
  alloc_result_t    pending_results[$];
  int unsigned      mismatch_count;
  logic             calm;
  logic             hold_off_req;
  plan_row_t        directed_plan [28];

  function automatic void load_capacity(input logic [CNT_W-1:0] value);
    model_capacity = (value > SLOTS) ? SLOTS : value;
    model_free_map = '0;
    for (int i = 0; i < model_capacity; i++) model_free_map[i] = 1'b1;
    model_free_total = model_capacity;
  endfunction

  function automatic alloc_result_t predict_request(input logic act,
                                                    input logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int unsigned i;
    r = '0;
    if (act == ACT_ALLOC) begin
      i = 0;
      while (i < model_capacity && !r.ok) begin
        if (model_free_map[i]) begin
          model_free_map[i] = 1'b0;
          model_free_total--;
          r.ok = 1'b1;
          r.slot = i[IDX_W-1:0];
        end
        i++;
      end
    end else if (idx < model_capacity) begin
      r.ok = 1'b1;
      if (!model_free_map[idx]) begin
        model_free_map[idx] = 1'b1;
        model_free_total++;
      end
    end
    r.free_count = model_free_total[CNT_W-1:0];
    r.empty = (model_free_total == 0);
    r.full = (model_free_total == model_capacity);
    return r;
  endfunction

  task automatic issue(input logic act, input logic [IDX_W-1:0] idx, input logic typed,
                       input alloc_result_t given);
    alloc_result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.action <= act;
    req_bus.slot_index <= idx;
    do @(posedge clk); while (!req_bus.ready);
    predicted = predict_request(act, idx);
    pending_results.push_back(typed ? given : predicted);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    load_capacity(value);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        res_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.ok, res_bus.granted_slot, res_bus.free_count,
              res_bus.pool_empty, res_bus.pool_full};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result beat: ok=%0d slot=%0d free=%0d empty=%0d full=%0d",
                   got.ok, got.slot, got.free_count, got.empty, got.full);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.slot !== want.slot ||
            got.free_count !== want.free_count || got.empty !== want.empty ||
            got.full !== want.full) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("result mismatch: want ok=%0d slot=%0d free=%0d empty=%0d full=%0d, ",
                   want.ok, want.slot, want.free_count, want.empty, want.full);
            $display("got ok=%0d slot=%0d free=%0d empty=%0d full=%0d",
                     got.ok, got.slot, got.free_count, got.empty, got.full);
          end
        end
      end
    end
  end

  initial begin
    int unsigned      cap_val;
    logic             act;
    logic [IDX_W-1:0] idx;
    directed_plan = '{
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b1, 9'd1, 10'd510, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      // double release
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd511, 10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_RELEASE, 9'd1,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b0, '0},
      // zero capacity
      '{ROW_CAP, ACT_ALLOC,   9'd0,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b0, 9'd0, 10'd0, 1'b1, 1'b1}},
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b1, '{1'b0, 9'd0, 10'd0, 1'b1, 1'b1}},
      '{ROW_REQ, ACT_RELEASE, 9'd511, 10'd0,    1'b1, '{1'b0, 9'd0, 10'd0, 1'b1, 1'b1}},
      '{ROW_CAP, ACT_ALLOC,   9'd0,   10'd1,    1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd0, 1'b1, 1'b0}},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b0, 9'd0, 10'd0, 1'b1, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd1,   10'd0,    1'b1, '{1'b0, 9'd0, 10'd0, 1'b1, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd1, 1'b0, 1'b1}},
      // oversized capacity saturates
      '{ROW_CAP, ACT_ALLOC,   9'd0,   10'd1023, 1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd511, 10'd0,    1'b1, '{1'b1, 9'd0, 10'd511, 1'b0, 1'b0}},
      '{ROW_REQ, ACT_RELEASE, 9'd0,   10'd0,    1'b1, '{1'b1, 9'd0, 10'd512, 1'b0, 1'b1}},
      '{ROW_CAP, ACT_ALLOC,   9'd0,   10'd513,  1'b0, '0},
      '{ROW_REQ, ACT_RELEASE, 9'd510, 10'd0,    1'b1, '{1'b1, 9'd0, 10'd512, 1'b0, 1'b1}},
      '{ROW_CAP, ACT_ALLOC,   9'd0,   10'd2,    1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_ALLOC,   9'd0,   10'd0,    1'b0, '0},
      '{ROW_REQ, ACT_RELEASE, 9'd2,   10'd0,    1'b0, '0}
    };
    mismatch_count = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    load_capacity(CNT_W'(SLOTS));
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.action <= ACT_ALLOC;
    req_bus.slot_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CAP)
        write_capacity(directed_plan[r].cap);
      else
        issue(directed_plan[r].act, directed_plan[r].idx, directed_plan[r].typed,
              directed_plan[r].want);
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cap_val = SLOTS;
        1: cap_val = $urandom_range(16, 1);
        2: cap_val = $urandom_range(64, 17);
        3: cap_val = $urandom_range(1023, SLOTS + 1);
        4: cap_val = $urandom_range(8, 1);
        5: cap_val = 0;
        6: cap_val = $urandom_range(SLOTS - 1, 65);
        default: cap_val = $urandom_range(32, 1);
      endcase
      write_capacity(cap_val[CNT_W-1:0]);
      calm = (phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 10) hold_off_req = 1'b1;
        if (phase == 2 && n == 40) drain();
        // fill in the first half, empty out in the second
        if (n < PHASE_ITEMS / 2) act = ($urandom_range(99) < 70) ? ACT_ALLOC : ACT_RELEASE;
        else act = ($urandom_range(99) < 30) ? ACT_ALLOC : ACT_RELEASE;
        if (model_capacity == 0 || $urandom_range(99) < 20)
          idx = IDX_W'($urandom_range(SLOTS - 1));
        else
          idx = IDX_W'($urandom_range(model_capacity - 1));
        issue(act, idx, 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
